// ----- sv/pis_pkg.sv -----
// Package with shared constants and types for the integral-separation PID block.
`default_nettype none

package pis_pkg;

    localparam int GAIN_W  = 16;
    localparam int LEVEL_W = 12;
    localparam int ERR_W   = 13;
    localparam int SUM_W   = 32;
    localparam int ACC_W   = 40;
    localparam int FRAC_W  = 16;
    localparam int WHOLE_W = 24;
    localparam int RATE_W  = 7;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P    = 3'd0,
        CFG_GAIN_I    = 3'd1,
        CFG_GAIN_D    = 3'd2,
        CFG_TARGET    = 3'd3,
        CFG_SEP_THR   = 3'd4,
        CFG_INIT_DRV  = 3'd5
    } cfg_idx_t;

    localparam logic [GAIN_W-1:0]  GAIN_P_RST  = 16'd1573;
    localparam logic [GAIN_W-1:0]  GAIN_I_RST  = 16'd983;
    localparam logic [GAIN_W-1:0]  GAIN_D_RST  = 16'd0;
    localparam logic [LEVEL_W-1:0] TARGET_RST  = 12'd1632;
    localparam logic [LEVEL_W-1:0] SEP_THR_RST = 12'd25;
    localparam logic [7:0]         INIT_DRV_RST = 8'd40;

    localparam logic [ACC_W-1:0] ACC_RST = {16'd0, INIT_DRV_RST, 16'd0};
    localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    localparam logic [RATE_W-1:0] RATE_LOW_VAL  = 7'd10;
    localparam logic [RATE_W-1:0] RATE_HIGH_VAL = 7'd95;
    localparam logic signed [WHOLE_W-1:0] RATE_LOW_LIM  = 24'sd2;
    localparam logic signed [WHOLE_W-1:0] RATE_HIGH_LIM = 24'sd101;

endpackage

`default_nettype wire

// ----- sv/pid_integral_separation.sv -----
// An accepted input goes to the input register, then to the result register.
// Throughput: one item per cycle when out_stall is low; an item can enter while a result waits.
// The error sum, drive accumulator and stored follow-up update in the cycle a result is registered.
// Reset (rst_n low, asynchronous) loads the default gains, setpoint and threshold, clears the
// error sum and stored follow-up, and loads the drive accumulator with the default initial drive.
// A write of the initial drive register is accepted but only the reset value is ever loaded.
`default_nettype none

module pid_integral_separation (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [pis_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [pis_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [pis_pkg::LEVEL_W-1:0]   measured,
    input  wire logic [pis_pkg::LEVEL_W-1:0]   follow_up_measured,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic signed [pis_pkg::ERR_W-1:0]   error_value,
    output logic signed [pis_pkg::WHOLE_W-1:0] drive_whole,
    output logic [pis_pkg::RATE_W-1:0]         modulation_rate
);
    import pis_pkg::*;

    logic [GAIN_W-1:0]  gain_p_reg, gain_i_reg, gain_d_reg;
    logic [LEVEL_W-1:0] target_reg, sep_thr_reg;

    logic               s1_valid_reg, s1_valid_next;
    logic [LEVEL_W-1:0] meas_reg, follow_reg;
    logic               out_valid_reg, out_valid_next;
    logic signed [ERR_W-1:0] error_value_reg;

    logic signed [SUM_W-1:0] error_sum_reg, error_sum_next;
    logic signed [ACC_W-1:0] drive_acc_reg, drive_acc_next;
    logic [LEVEL_W-1:0]      prev_follow_reg;

    logic in_accept, s1_advance, out_advance;

    logic signed [ERR_W-1:0]   err, diff;
    logic [SUM_W:0]            sum_wide;
    logic signed [29:0]        p_term, d_term;
    logic signed [48:0]        i_term;
    logic                      use_integral;
    logic [49:0]               total;
    logic [ACC_W-1:0]          biased;
    logic signed [WHOLE_W-1:0] whole;

    // Handshake: the input stage moves on whenever the result register is free or being emptied.
    assign out_advance = out_valid_reg && !out_stall;
    assign s1_advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall    = s1_valid_reg && !s1_advance;
    assign in_accept   = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
            s1_valid_next = 1'b1;
        else if (s1_advance)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (s1_advance)
            out_valid_next = 1'b1;
        else if (out_advance)
            out_valid_next = 1'b0;
    end

    // Controller arithmetic for the item held in the input register.
    always_comb
    begin
        err  = $signed({1'b0, target_reg}) - $signed({1'b0, meas_reg});
        diff = $signed({1'b0, meas_reg}) - $signed({1'b0, prev_follow_reg});

        sum_wide = {error_sum_reg[SUM_W-1], error_sum_reg}
                 + {{(SUM_W+1-ERR_W){err[ERR_W-1]}}, err};
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
            error_sum_next = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
        else
            error_sum_next = sum_wide[SUM_W-1:0];

        p_term = $signed({1'b0, gain_p_reg}) * err;
        d_term = $signed({1'b0, gain_d_reg}) * diff;
        i_term = $signed({1'b0, gain_i_reg}) * error_sum_next;
        use_integral = err < $signed({1'b0, sep_thr_reg});

        total = {{10{drive_acc_reg[ACC_W-1]}}, drive_acc_reg}
              + {{20{p_term[29]}}, p_term}
              + {{20{d_term[29]}}, d_term}
              + (use_integral ? {i_term[48], i_term} : 50'd0);

        // The sum fits when every bit above the accumulator's sign bit matches it.
        if ((&total[49:ACC_W-1]) || !(|total[49:ACC_W-1]))
            drive_acc_next = total[ACC_W-1:0];
        else
            drive_acc_next = total[49] ? ACC_MIN : ACC_MAX;
    end

    // The whole part and rate follow the accumulator, which only changes with a new result.
    always_comb
    begin
        biased = drive_acc_reg
               + {{(ACC_W-FRAC_W){1'b0}}, {FRAC_W{drive_acc_reg[ACC_W-1]}}};
        whole  = biased[ACC_W-1:FRAC_W];
        if (whole < RATE_LOW_LIM)
            modulation_rate = RATE_LOW_VAL;
        else if (whole > RATE_HIGH_LIM)
            modulation_rate = RATE_HIGH_VAL;
        else
            modulation_rate = whole[RATE_W-1:0];
    end

    assign drive_whole = whole;
    assign error_value = error_value_reg;
    assign out_valid   = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg  <= GAIN_P_RST;
            gain_i_reg  <= GAIN_I_RST;
            gain_d_reg  <= GAIN_D_RST;
            target_reg  <= TARGET_RST;
            sep_thr_reg <= SEP_THR_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GAIN_P:  gain_p_reg  <= cfg_data;
                CFG_GAIN_I:  gain_i_reg  <= cfg_data;
                CFG_GAIN_D:  gain_d_reg  <= cfg_data;
                CFG_TARGET:  target_reg  <= cfg_data[LEVEL_W-1:0];
                CFG_SEP_THR: sep_thr_reg <= cfg_data[LEVEL_W-1:0];
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            error_sum_reg   <= '0;
            drive_acc_reg   <= ACC_RST;
            prev_follow_reg <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_advance)
            begin
                error_sum_reg   <= error_sum_next;
                drive_acc_reg   <= drive_acc_next;
                prev_follow_reg <= follow_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            meas_reg   <= measured;
            follow_reg <= follow_up_measured;
        end
        if (s1_advance)
            error_value_reg <= err;
    end

    // The input side is only held back by an occupied input register.
    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg)
        else $error("input stalled with an empty input register");

    // Controller state must hold while a result waits to be taken.
    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> ($stable(drive_acc_reg) && $stable(error_sum_reg)))
        else $error("controller state changed while a result was stalled");

    // Every item leaving the input register produces a result in the next cycle.
    a_advance_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance |=> out_valid_reg)
        else $error("item left the input register without a result");

    // The rate map never leaves its documented range.
    a_rate_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (modulation_rate >= 7'd2 && modulation_rate <= 7'd101))
        else $error("modulation rate out of range");

endmodule

`default_nettype wire
